/* hw/rtl/alist_pkg.sv */
`timescale 1ns / 1ps

package alist_pkg;

  // Capacity of the list and the fixed field widths of the request and result.
  localparam int DEPTH  = 32;
  localparam int WORD_W = 32;
  localparam int POS_W  = 6;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 6;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SEARCH = 3'd4,
    OP_SORT   = 3'd5,
    OP_DUMP   = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  // What one cell loads on the next clock edge.
  typedef enum logic [2:0] {
    CM_HOLD  = 3'd0,
    CM_KEY   = 3'd1,
    CM_LEFT  = 3'd2,
    CM_RIGHT = 3'd3,
    CM_LOW   = 3'd4,
    CM_HIGH  = 3'd5
  } cell_mode_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
    word_t             value;
  } request_t;

  typedef struct packed {
    status_t           status;
    word_t             data;
    logic [IDX_W-1:0]  index;
    logic [CNT_W-1:0]  count;
    logic              last;
  } result_t;

endpackage

/* hw/rtl/alist_cell.sv */
`timescale 1ns / 1ps

module alist_cell
  import alist_pkg::*;
(
  input  logic       clk,
  input  cell_mode_t mode,
  input  word_t      key,
  input  word_t      left_word,
  input  word_t      right_word,
  output word_t      word
);

  word_t word_next;

  // The low cell of a compare pair keeps the smaller word, the high cell the
  // larger one; a strict compare keeps equal words in their order.
  always_comb begin
    word_next = word;
    unique case (mode)
      CM_HOLD:  word_next = word;
      CM_KEY:   word_next = key;
      CM_LEFT:  word_next = left_word;
      CM_RIGHT: word_next = right_word;
      CM_LOW:   word_next = (word > right_word) ? right_word : word;
      CM_HIGH:  word_next = (left_word > word) ? left_word : word;
      default:  word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

/* hw/rtl/array_list_insert_remove_search_sort_unit.sv */
`timescale 1ns / 1ps

// Channel   | Ports                  | Moves
// ----------+------------------------+-------------------------------------------
// request   | start, busy, request   | op, position, value; taken on start && !busy
// result    | valid, result          | status, data, index, count, last; one cycle
//
// Clear, append, insert and remove finish at the edge that takes the request;
// their result shows in the next cycle and busy stays low, so these requests
// can follow each other in every cycle.
// Search, sort and dump keep busy high after the request until they finish:
// search and dump rotate the whole cell chain once, sort runs DEPTH odd-even
// compare-exchange phases along the chain. A dump gives one result per cycle.
// An empty list (or fewer than two words for sort) answers in the next cycle without raising busy.
// Reset clears the count and the control state; the words are not cleared.
// The receiver cannot stall: each result is held for exactly one cycle.

module array_list_insert_remove_search_sort_unit
  import alist_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     valid,
  output result_t  result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SORT,
    S_DUMP
  } state_t;

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] step;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  word_t            key;

  word_t            cell_word [DEPTH];
  cell_mode_t       cell_mode [DEPTH];

  logic             full;
  logic             app_ok;
  logic             ins_ok;
  logic             rem_ok;
  logic [CNT_W-1:0] rem_pos;
  logic [CNT_W-1:0] count_next;
  status_t          op_status;
  logic             step_live;
  logic             hit;

  assign busy = (state != S_IDLE);

  // Checks of the list edits against the current count.
  assign full    = (count == CNT_W'(DEPTH));
  assign app_ok  = !full;
  assign ins_ok  = (request.position <= count) && !full;
  assign rem_ok  = (count != '0) && (request.position != '0) && (request.position <= count);
  assign rem_pos = request.position - CNT_W'(1);

  always_comb begin
    op_status  = ST_OK;
    count_next = count;
    unique case (request.op)
      OP_CLEAR: begin
        count_next = '0;
      end
      OP_APPEND: begin
        if (app_ok) begin
          count_next = count + CNT_W'(1);
        end else begin
          op_status = ST_FULL;
        end
      end
      OP_INSERT: begin
        if (request.position > count) begin
          op_status = ST_RANGE;
        end else if (full) begin
          op_status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (count == '0) begin
          op_status = ST_EMPTY;
        end else if (!rem_ok) begin
          op_status = ST_RANGE;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      OP_SEARCH, OP_DUMP: begin
        if (count == '0) begin
          op_status = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  // While rotating, cell 0 holds the word whose index equals the step count.
  assign step_live = ({1'b0, step} < count);
  assign hit       = step_live && (cell_word[0] == key);

  // Per-cell load control. Insert moves the words from the position up one
  // cell, remove moves the words from the position down one cell, and search
  // and dump rotate the chain toward cell 0 so that every word passes there.
  // Sort pairs cells (even, odd) on even steps and (odd, even) on odd steps.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_mode[i] = CM_HOLD;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (request.op)
              OP_APPEND: begin
                if (app_ok && (CNT_W'(i) == count)) begin
                  cell_mode[i] = CM_KEY;
                end
              end
              OP_INSERT: begin
                if (ins_ok && (CNT_W'(i) == request.position)) begin
                  cell_mode[i] = CM_KEY;
                end else if (ins_ok && (CNT_W'(i) > request.position)) begin
                  cell_mode[i] = CM_LEFT;
                end
              end
              OP_REMOVE: begin
                if (rem_ok && (CNT_W'(i) >= rem_pos)) begin
                  cell_mode[i] = CM_RIGHT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SORT: begin
          if ((1'(i) == step[0]) && (CNT_W'(i + 1) < count)) begin
            cell_mode[i] = CM_LOW;
          end else if ((i > 0) && (1'(i) != step[0]) && (CNT_W'(i) < count)) begin
            cell_mode[i] = CM_HIGH;
          end
        end
        S_SEARCH, S_DUMP: begin
          cell_mode[i] = CM_RIGHT;
        end
        default: begin
        end
      endcase
    end
  end

  // The chain closes into a ring so that a full rotation restores the order.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int LEFT_IDX  = (g + DEPTH - 1) % DEPTH;
    localparam int RIGHT_IDX = (g + 1) % DEPTH;

    alist_cell u_cell (
      .clk        (clk),
      .mode       (cell_mode[g]),
      .key        (request.value),
      .left_word  (cell_word[LEFT_IDX]),
      .right_word (cell_word[RIGHT_IDX]),
      .word       (cell_word[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= 1'b0;
      count     <= '0;
      step      <= '0;
      found     <= 1'b0;
      found_idx <= '0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            step          <= '0;
            found         <= 1'b0;
            found_idx     <= '0;
            key           <= request.value;
            count         <= count_next;
            result.status <= op_status;
            result.data   <= '0;
            result.index  <= '0;
            result.count  <= count_next;
            result.last   <= 1'b1;
            valid         <= 1'b1;
            unique case (request.op)
              OP_SEARCH: begin
                if (count != '0) begin
                  state <= S_SEARCH;
                  valid <= 1'b0;
                end
              end
              OP_DUMP: begin
                if (count != '0) begin
                  state <= S_DUMP;
                  valid <= 1'b0;
                end
              end
              OP_SORT: begin
                if (count > CNT_W'(1)) begin
                  state <= S_SORT;
                  valid <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SEARCH: begin
          step <= step + IDX_W'(1);
          if (hit && !found) begin
            found     <= 1'b1;
            found_idx <= step;
          end
          if (step == LAST_STEP) begin
            state         <= S_IDLE;
            valid         <= 1'b1;
            result.status <= (found || hit) ? ST_OK : ST_MISSING;
            result.data   <= '0;
            result.index  <= found ? found_idx : (hit ? step : '0);
            result.count  <= count;
            result.last   <= 1'b1;
          end
        end
        S_SORT: begin
          step <= step + IDX_W'(1);
          if (step == LAST_STEP) begin
            state         <= S_IDLE;
            valid         <= 1'b1;
            result.status <= ST_OK;
            result.data   <= '0;
            result.index  <= '0;
            result.count  <= count;
            result.last   <= 1'b1;
          end
        end
        S_DUMP: begin
          step <= step + IDX_W'(1);
          if (step_live) begin
            valid         <= 1'b1;
            result.status <= ST_OK;
            result.data   <= cell_word[0];
            result.index  <= step;
            result.count  <= count;
            result.last   <= ({1'b0, step} == (count - CNT_W'(1)));
          end
          if (step == LAST_STEP) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/alist_chk.sv */
`timescale 1ns / 1ps

module alist_chk
  import alist_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input request_t request,
  input logic     valid,
  input result_t  result
);

  // Reset leaves the unit idle with no result on the port.
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !valid)
    else $error("unit not idle after reset");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid |-> (result.count <= CNT_W'(DEPTH)))
    else $error("result count above capacity");

  // List edits answer with a single final result in the next cycle.
  a_edit_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.op == OP_CLEAR || request.op == OP_APPEND ||
                        request.op == OP_INSERT || request.op == OP_REMOVE))
    |=> valid && result.last && !busy)
    else $error("edit request without immediate result");

  // A result that is not the last one belongs to a dump still in progress.
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (valid && !result.last) |-> busy && (result.status == ST_OK))
    else $error("intermediate result while idle");

endmodule

bind array_list_insert_remove_search_sort_unit alist_chk u_alist_chk (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import alist_pkg::*;

  // Op code 7 is not part of the package enum; the block must answer it with
  // a plain ok result carrying the current count.
  localparam logic [2:0] OP_SPARE = 3'd7;

  // Cycles allowed after the last expected result for stray results to show.
  localparam int DRAIN_CYCLES = 40;
  // Hard stop; the slowest correct run needs a small fraction of this.
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS  = 10;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  request_t request = '0;
  logic     valid;
  result_t  result;

  // Requests waiting to be driven, and results the list is expected to give.
  request_t pending_requests[$];
  result_t  expected_results[$];

  // Shadow copy of the list contents as the predictor sees them.
  word_t    shadow_words[DEPTH];
  int       shadow_count = 0;

  // Count as seen while the stimulus is planned, used to pick positions and to fill the list.
  int       planned_count = 0;
  word_t    value_pool[8];

  int       total_requests = 0;
  int       issued_count = 0;
  int       error_count = 0;
  int       cycle_count = 0;
  result_t  oldest_result;

  array_list_insert_remove_search_sort_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .valid   (valid),
    .result  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out what the list answers to one request and update the shadow copy.
  // Every request gives one result, except a dump of a non-empty list, which
  // gives one result per element with last set on the final one.
  task automatic apply_list_op(input request_t req);
    int      i;
    int      j;
    int      found;
    word_t   tmp;
    status_t st;
    result_t res;
    begin
      st    = ST_OK;
      found = 0;
      case (req.op)
        OP_CLEAR: begin
          shadow_count = 0;
        end
        OP_APPEND: begin
          if (shadow_count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            shadow_words[shadow_count] = req.value;
            shadow_count++;
          end
        end
        OP_INSERT: begin
          if (int'(req.position) > shadow_count) begin
            st = ST_RANGE;
          end else if (shadow_count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            for (i = shadow_count; i > int'(req.position); i--)
              shadow_words[i] = shadow_words[i-1];
            shadow_words[req.position] = req.value;
            shadow_count++;
          end
        end
        OP_REMOVE: begin
          // Remove positions count from one, unlike insert positions.
          if (shadow_count == 0) begin
            st = ST_EMPTY;
          end else if (req.position == 0 || int'(req.position) > shadow_count) begin
            st = ST_RANGE;
          end else begin
            for (i = req.position; i < shadow_count; i++)
              shadow_words[i-1] = shadow_words[i];
            shadow_count--;
          end
        end
        OP_SEARCH: begin
          if (shadow_count == 0) begin
            st = ST_EMPTY;
          end else begin
            st = ST_MISSING;
            for (i = 0; i < shadow_count; i++) begin
              if (st == ST_MISSING && shadow_words[i] == req.value) begin
                st    = ST_OK;
                found = i;
              end
            end
          end
        end
        OP_SORT: begin
          // Plain bubble sort on signed words; equal words never swap.
          for (i = 0; i + 1 < shadow_count; i++) begin
            for (j = 0; j + 1 < shadow_count; j++) begin
              if (shadow_words[j] > shadow_words[j+1]) begin
                tmp               = shadow_words[j];
                shadow_words[j]   = shadow_words[j+1];
                shadow_words[j+1] = tmp;
              end
            end
          end
        end
        OP_DUMP: begin
          if (shadow_count == 0) begin
            st = ST_EMPTY;
          end else begin
            for (i = 0; i < shadow_count; i++) begin
              res.status = ST_OK;
              res.data   = shadow_words[i];
              res.index  = i[IDX_W-1:0];
              res.count  = shadow_count[CNT_W-1:0];
              res.last   = (i + 1 == shadow_count);
              expected_results.push_back(res);
            end
          end
        end
        default: begin
        end
      endcase
      if (!(req.op == OP_DUMP && shadow_count != 0)) begin
        res.status = st;
        res.data   = '0;
        res.index  = found[IDX_W-1:0];
        res.count  = shadow_count[CNT_W-1:0];
        res.last   = 1'b1;
        expected_results.push_back(res);
      end
    end
  endtask

  // Queue one request and keep the planned count in step, so that later
  // positions can be aimed at the legal range most of the time.
  task automatic queue_request(input logic [2:0] op_code, input int pos, input word_t val);
    request_t req;
    begin
      req.op       = op_t'(op_code);
      req.position = pos[POS_W-1:0];
      req.value    = val;
      pending_requests.push_back(req);
      case (op_code)
        OP_CLEAR:  planned_count = 0;
        OP_APPEND: if (planned_count < DEPTH) planned_count++;
        OP_INSERT: if (req.position <= planned_count && planned_count < DEPTH) planned_count++;
        OP_REMOVE: begin
          if (planned_count > 0 && req.position >= 1 && req.position <= planned_count)
            planned_count--;
        end
        default: begin
        end
      endcase
    end
  endtask

  // Half of the words come from a small pool, so that searches hit and the
  // sort sees equal words and the extremes; the rest are fully random.
  function automatic word_t pick_word();
    if ($urandom_range(0, 1) == 0)
      return value_pool[$urandom_range(0, 7)];
    return word_t'($urandom);
  endfunction

  task automatic add_random_requests(input int n);
    int k;
    int r;
    int pos;
    begin
      for (k = 0; k < n; k++) begin
        r   = $urandom_range(0, 99);
        // Most positions land in the legal range; the rest sweep all six bits.
        pos = $urandom_range(0, 63);
        if (r < 25) begin
          queue_request(OP_APPEND, pos, pick_word());
        end else if (r < 45) begin
          if ($urandom_range(0, 99) < 85) pos = $urandom_range(0, planned_count);
          queue_request(OP_INSERT, pos, pick_word());
        end else if (r < 60) begin
          if ($urandom_range(0, 99) < 85 && planned_count > 0)
            pos = $urandom_range(1, planned_count);
          queue_request(OP_REMOVE, pos, word_t'($urandom));
        end else if (r < 72) begin
          queue_request(OP_SEARCH, pos, pick_word());
        end else if (r < 80) begin
          queue_request(OP_SORT, pos, word_t'($urandom));
        end else if (r < 92) begin
          queue_request(OP_DUMP, pos, word_t'($urandom));
        end else if (r < 96) begin
          queue_request(OP_CLEAR, pos, word_t'($urandom));
        end else begin
          queue_request(OP_SPARE, pos, word_t'($urandom));
        end
      end
    end
  endtask

  // Bring the list to capacity and work the edges of a full list.
  task automatic add_fill_sequence();
    begin
      queue_request(OP_CLEAR, 0, '0);
      while (planned_count < DEPTH) begin
        if ($urandom_range(0, 3) == 0)
          queue_request(OP_INSERT, $urandom_range(0, planned_count), pick_word());
        else
          queue_request(OP_APPEND, $urandom_range(0, 63), pick_word());
      end
      queue_request(OP_APPEND, 0, pick_word());
      queue_request(OP_INSERT, DEPTH, pick_word());
      queue_request(OP_INSERT, DEPTH + 1, pick_word());
      queue_request(OP_INSERT, 0, pick_word());
      queue_request(OP_SEARCH, 0, value_pool[$urandom_range(0, 7)]);
      queue_request(OP_SORT, 0, '0);
      queue_request(OP_DUMP, 0, '0);
      queue_request(OP_REMOVE, DEPTH + 1, '0);
      queue_request(OP_REMOVE, DEPTH, '0);
      queue_request(OP_INSERT, DEPTH - 1, pick_word());
      queue_request(OP_REMOVE, 1, '0);
      queue_request(OP_SEARCH, 0, word_t'($urandom));
      queue_request(OP_DUMP, 0, '0);
    end
  endtask

  // The sender idles 19 percent of the time in the first third of the run,
  // 67 percent in the second third, and not at all in the last third.
  function automatic int idle_percent();
    if (issued_count * 3 < total_requests)
      return 19;
    if (issued_count * 3 < total_requests * 2)
      return 67;
    return 0;
  endfunction

  // Driver. A request is taken at an edge where start is high and busy low;
  // the predictor runs at that same edge, so expectations line up with the
  // order in which the list takes requests. A request that is held off by
  // busy stays on the ports unchanged.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        apply_list_op(request);
      if (!(start && busy)) begin
        if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_percent()) begin
          start   <= 1'b1;
          request <= pending_requests.pop_front();
          issued_count++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. A result is present for exactly one cycle, so it is sampled at
  // the edge that ends that cycle and checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (expected_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected result: status %0d data %0d index %0d count %0d last %0d",
                   result.status, result.data, result.index, result.count, result.last);
        error_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (result.status !== oldest_result.status || result.data !== oldest_result.data ||
            result.index !== oldest_result.index || result.count !== oldest_result.count ||
            result.last !== oldest_result.last) begin
          if (error_count < MAX_REPORTS)
            $display("mismatch at %0t: expected status %0d data %0d index %0d count %0d ",
                     $realtime, oldest_result.status, oldest_result.data,
                     oldest_result.index, oldest_result.count,
                     "last %0d, got status %0d data %0d index %0d count %0d last %0d",
                     oldest_result.last,
                     result.status, result.data, result.index, result.count, result.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (int k = 4; k < 8; k++)
      value_pool[k] = word_t'($urandom);

    // Directed part: every empty-list answer, the unused op code, inserts at
    // and past the end, bad remove positions, a search hit and a miss, a sort
    // of one word and of several with the extreme values, and dumps.
    queue_request(OP_DUMP, 0, '0);
    queue_request(OP_SEARCH, 0, '0);
    queue_request(OP_REMOVE, 1, '0);
    queue_request(OP_SORT, 0, '0);
    queue_request(OP_INSERT, 1, 32'sd7);
    queue_request(OP_SPARE, 63, -32'sd1);
    queue_request(OP_INSERT, 0, 32'sh7FFF_FFFF);
    queue_request(OP_SORT, 0, '0);
    queue_request(OP_APPEND, 0, 32'sh8000_0000);
    queue_request(OP_INSERT, 2, -32'sd1);
    queue_request(OP_INSERT, 1, 32'sd5);
    queue_request(OP_APPEND, 63, 32'sd5);
    queue_request(OP_SEARCH, 0, 32'sd5);
    queue_request(OP_SEARCH, 0, 32'sd12345);
    queue_request(OP_REMOVE, 0, '0);
    queue_request(OP_REMOVE, 6, '0);
    queue_request(OP_INSERT, 63, 32'sd9);
    queue_request(OP_DUMP, 0, '0);
    queue_request(OP_SORT, 0, '0);
    queue_request(OP_DUMP, 0, '0);
    queue_request(OP_REMOVE, 5, '0);
    queue_request(OP_REMOVE, 1, '0);
    queue_request(OP_CLEAR, 0, '0);
    queue_request(OP_DUMP, 0, '0);
    queue_request(OP_APPEND, 0, 32'sd1);

    // Random part, with one run up to a full list in the middle.
    add_random_requests(15);
    add_fill_sequence();
    add_random_requests(15);
    total_requests = pending_requests.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait until every request is taken and every result has come, sampling
    // away from the rising edge so the driver's updates have settled.
    do
      @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/alist_pkg.sv
hw/rtl/alist_cell.sv
hw/rtl/array_list_insert_remove_search_sort_unit.sv
hw/rtl/alist_chk.sv
test/tb_top.sv
